@@ rtl/core/delta_sequence_match_finder_unit_assert.svh @@
// Assertion macros shared by the delta sequence match finder RTL.
`ifndef DELTA_SEQUENCE_MATCH_FINDER_UNIT_ASSERT_SVH
`define DELTA_SEQUENCE_MATCH_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dsmf_pkg.sv @@
// Shared types, constants and helpers of the delta sequence match finder.
`timescale 1ns / 1ps
package dsmf_pkg;

  // Number of back-distances checked per query.
  localparam int unsigned NUM_DIST = 4;

  // Accepted delta window: 0xC0..0xFF (negative) and 0x01..0x40 (positive).
  localparam logic [7:0] DELTA_NEG_LIMIT = 8'hC0;
  localparam logic [7:0] DELTA_POS_LIMIT = 8'h40;

  // Largest run length the 10-bit result field can carry.
  localparam int unsigned RUN_FIELD_MAX = 1023;
  localparam int unsigned RUN_FIELD_W   = 10;

  // Operation codes carried on the input tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer commands to the lane datapath.
  typedef struct packed {
    logic                shift;  // a fetched byte arrives: push it into the window
    logic                seed;   // the arriving byte is the query byte
    logic                step;   // the arriving byte extends the runs
    logic [NUM_DIST-1:0] en;     // distance lies within the position
  } lane_ctrl_t;

  // Delta is nonzero and inside the accepted window.
  function automatic logic delta_ok(input logic [7:0] d);
    delta_ok = (d != 8'h00) && ((d >= DELTA_NEG_LIMIT) || (d <= DELTA_POS_LIMIT));
  endfunction

endpackage

@@ rtl/core/dsmf_byte_mem.sv @@
// Byte buffer memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module dsmf_byte_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Store a byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Fetch a byte; the read data is registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dsmf_delta_lanes.sv @@
// Byte window and the four distance lanes: delta capture and run counting.
`timescale 1ns / 1ps
module dsmf_delta_lanes #(
  parameter int unsigned RUN_W = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dsmf_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [7:0]                           data_i,
  output logic [dsmf_pkg::NUM_DIST-1:0]        act_o,
  output logic [dsmf_pkg::NUM_DIST-1:0][7:0]   delta_o,
  output logic [dsmf_pkg::NUM_DIST-1:0][RUN_W-1:0] run_o
);

  localparam int unsigned ND = dsmf_pkg::NUM_DIST;

  // win_q[j] holds the byte j+1 places before the arriving one
  logic [ND-1:0][7:0]       win_q, win_d;
  logic [ND-1:0][7:0]       delta_q, delta_d;
  logic [ND-1:0][RUN_W-1:0] run_q, run_d;
  logic [ND-1:0]            act_q, act_d;
  logic [ND-1:0][7:0]       diff;
  logic [ND-1:0]            match;

  // Compare the arriving byte against every distance at once
  always_comb begin
    win_d   = win_q;
    delta_d = delta_q;
    run_d   = run_q;
    act_d   = act_q;
    for (int j = 0; j < ND; j++) begin
      diff[j]  = data_i - win_q[j];
      match[j] = (data_i == 8'(win_q[j] + delta_q[j]));
    end
    if (ctrl_i.shift) begin
      win_d[0] = data_i;
      for (int j = 1; j < ND; j++) begin
        win_d[j] = win_q[j-1];
      end
    end
    if (ctrl_i.seed) begin
      for (int j = 0; j < ND; j++) begin
        delta_d[j] = diff[j];
        act_d[j]   = ctrl_i.en[j] && dsmf_pkg::delta_ok(diff[j]);
        run_d[j]   = act_d[j] ? RUN_W'(1) : '0;
      end
    end else if (ctrl_i.step) begin
      for (int j = 0; j < ND; j++) begin
        if (act_q[j]) begin
          if (match[j]) begin
            run_d[j] = run_q[j] + RUN_W'(1);
          end else begin
            act_d[j] = 1'b0;
          end
        end
      end
    end
  end

  // Hold lane activity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else begin
      act_q <= act_d;
    end
  end

  // Hold window, deltas and run counts
  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    delta_q <= delta_d;
    run_q   <= run_d;
  end

  assign act_o   = act_q;
  assign delta_o = delta_q;
  assign run_o   = run_q;

endmodule

@@ rtl/core/delta_sequence_match_finder_unit.sv @@
// Top level of the delta sequence match finder: sequencer, buffer and result stage.
//
//  Channel   Direction  Moves
//  s_axis    in         one write or query per transfer
//  m_axis    out        one result per query transfer
//  cfg       in         buffer_length write, no handshake
//
// A write is stored as it is accepted, and the unit stays ready for the next. A query
// reads up to four bytes before the position and then the run, one memory read per
// cycle, checking all four distances on each byte, until no distance still matches
// or a length limit ends the walk; an out-of-range query skips the walk.
// Reset is asynchronous, active low; the buffer contents are not cleared. A
// stalled m_axis holds the next result in the sequencer until the output frees.
`timescale 1ns / 1ps
`include "delta_sequence_match_finder_unit_assert.svh"
module delta_sequence_match_finder_unit #(
  parameter int unsigned BUFFER_DEPTH   = 65536,
  parameter int unsigned MAX_RUN        = 512,
  parameter int unsigned MIN_RUN        = 1,
  parameter int unsigned FIRST_POSITION = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] position, [23:16] byte_value
  input  logic [23:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] query_position, [23:16] delta_offset1, [31:24] delta_offset2,
  // [39:32] delta_offset3, [47:40] delta_offset4, [57:48] run_length1,
  // [67:58] run_length2, [77:68] run_length3, [87:78] run_length4
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  localparam int unsigned ND    = dsmf_pkg::NUM_DIST;
  localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
  localparam int unsigned DLW   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned LW    = (DLW > 17) ? DLW : 17;
  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned PW    = $clog2(ND + 1);
  localparam int unsigned RFW   = dsmf_pkg::RUN_FIELD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_e;

  state_e          state_q;
  logic [16:0]     buf_len_q;
  logic [LW-1:0]   addr_q, limit_q, arr_q;
  logic [15:0]     pos_q;
  logic [ND-1:0]   en_q;
  logic            rv_q, seeded_q, use_lanes_q;
  logic            out_valid_q;
  logic [87:0]     out_data_q;

  logic [15:0]     in_pos;
  logic [7:0]      in_byte;
  logic            in_xfer;
  logic [LW-1:0]   eff_len, lim_run, start_addr, pos_ext;
  logic [PW-1:0]   npre;
  logic            range_ok, mem_we, issue, finish, out_load;
  logic [ND-1:0]   en_d;
  logic [7:0]      rdata;
  logic [87:0]     result;

  dsmf_pkg::lane_ctrl_t                 lane_ctrl;
  logic [ND-1:0]                        lane_act;
  logic [ND-1:0][7:0]                   lane_delta;
  logic [ND-1:0][RUN_W-1:0]             lane_run;

  assign in_pos  = s_axis_tdata[15:0];
  assign in_byte = s_axis_tdata[23:16];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign pos_ext = LW'(in_pos);

  // Clip the loaded length to the buffer depth and qualify the query
  always_comb begin
    eff_len    = (LW'(buf_len_q) > LW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : LW'(buf_len_q);
    range_ok   = (pos_ext >= LW'(FIRST_POSITION)) && (pos_ext + LW'(MIN_RUN) <= eff_len);
    npre       = (pos_ext < LW'(ND)) ? PW'(in_pos) : PW'(ND);
    start_addr = pos_ext - LW'(npre);
    lim_run    = pos_ext + LW'(MAX_RUN);
    for (int j = 0; j < ND; j++) begin
      en_d[j] = (pos_ext >= LW'(j + 1));
    end
  end

  assign mem_we = in_xfer && (s_axis_tuser == dsmf_pkg::OP_WRITE) &&
                  (pos_ext < LW'(BUFFER_DEPTH));
  assign issue  = (state_q == ST_SCAN) && (addr_q < limit_q);
  assign finish = (!issue && !rv_q) || (seeded_q && (lane_act == '0));

  // Steer the lanes from the fetch that lands this cycle
  always_comb begin
    lane_ctrl       = '0;
    lane_ctrl.en    = en_q;
    lane_ctrl.shift = rv_q;
    lane_ctrl.seed  = rv_q && (arr_q == LW'(pos_q));
    lane_ctrl.step  = rv_q && (arr_q > LW'(pos_q));
  end

  dsmf_byte_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(in_pos)),
    .wdata_i (in_byte),
    .re_i    (issue),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  dsmf_delta_lanes #(
    .RUN_W (RUN_W)
  ) u_lanes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .data_i  (rdata),
    .act_o   (lane_act),
    .delta_o (lane_delta),
    .run_o   (lane_run)
  );

  // Pack the result, zeroing short runs and saturating wide ones
  always_comb begin
    result        = '0;
    result[15:0]  = pos_q;
    if (use_lanes_q) begin
      for (int j = 0; j < ND; j++) begin
        if (32'(lane_run[j]) >= 32'(MIN_RUN)) begin
          result[16 + 8*j +: 8] = lane_delta[j];
          result[16 + 8*ND + RFW*j +: RFW] =
            (32'(lane_run[j]) > 32'(dsmf_pkg::RUN_FIELD_MAX)) ?
            RFW'(dsmf_pkg::RUN_FIELD_MAX) : RFW'(lane_run[j]);
        end
      end
    end
  end

  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Hold the length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= 17'd1;
    end else if (cfg_we_i) begin
      buf_len_q <= cfg_wdata_i;
    end
  end

  // Sequence the query walk and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rv_q        <= 1'b0;
      seeded_q    <= 1'b0;
      use_lanes_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      addr_q      <= '0;
      limit_q     <= '0;
      arr_q       <= '0;
      pos_q       <= '0;
      en_q        <= '0;
    end else begin
      rv_q  <= issue;
      arr_q <= addr_q;
      // Load a new result, or drop the one taken downstream
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= result;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (s_axis_tuser == dsmf_pkg::OP_QUERY)) begin
            pos_q       <= in_pos;
            en_q        <= en_d;
            addr_q      <= start_addr;
            limit_q     <= (lim_run < eff_len) ? lim_run : eff_len;
            seeded_q    <= 1'b0;
            use_lanes_q <= range_ok;
            state_q     <= range_ok ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            addr_q <= addr_q + LW'(1);
          end
          if (lane_ctrl.seed) begin
            seeded_q <= 1'b1;
          end
          if (finish) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `DSMF_ASSERT_NOW(a_walk_in_bounds, state_q == ST_SCAN, addr_q <= limit_q, "read address passed the scan limit")
  `DSMF_ASSERT_NOW(a_write_when_idle, mem_we, state_q == ST_IDLE, "buffer written outside idle")
  `DSMF_ASSERT_NOW(a_no_result_overrun, out_load, !out_valid_q || m_axis_tready, "pending result overwritten")
  `DSMF_ASSERT_NEXT(a_lane_seeded_runs, lane_ctrl.seed && (state_q == ST_SCAN), (lane_act == '0) || seeded_q, "lanes active without a seed")

endmodule

@@ verif/tb_delta_sequence_match_finder_unit.sv @@
// Testbench for the delta sequence match finder: directed and random stream traffic checked against a mirror.
`timescale 1ns / 1ps
module tb_delta_sequence_match_finder_unit;

  localparam int unsigned NUM_DIST        = dsmf_pkg::NUM_DIST;
  localparam int unsigned RUN_FIELD_W     = dsmf_pkg::RUN_FIELD_W;
  localparam int unsigned RUN_FIELD_MAX   = dsmf_pkg::RUN_FIELD_MAX;
  localparam logic [7:0]  DELTA_NEG_LIMIT = dsmf_pkg::DELTA_NEG_LIMIT;
  localparam logic [7:0]  DELTA_POS_LIMIT = dsmf_pkg::DELTA_POS_LIMIT;
  localparam logic        OP_WRITE        = dsmf_pkg::OP_WRITE;
  localparam logic        OP_QUERY        = dsmf_pkg::OP_QUERY;

  localparam int unsigned DEPTH         = 65536;
  localparam int unsigned MAX_RUN       = 512;
  localparam int unsigned MIN_RUN       = 1;
  localparam int unsigned FIRST_POS     = 1;
  // Longest query walk plus pipeline slack.
  localparam int unsigned SETTLE_CYCLES = MAX_RUN + 28;
  localparam int          TIMEOUT_NS    = 10_000_000;

  // One query result, laid out as on m_axis_tdata (lowest field last).
  typedef struct packed {
    logic [NUM_DIST-1:0][RUN_FIELD_W-1:0] run_len;
    logic [NUM_DIST-1:0][7:0]             delta;
    logic [15:0]                          qpos;
  } match_result_t;

  // Mirror of the buffer and the length, plus the queue of pending match results.
  class match_scoreboard;
    bit [7:0]      image[DEPTH];
    bit            loaded[DEPTH];
    bit [16:0]     buf_len = 17'd1;
    match_result_t expected_matches[$];
    int            n_writes;
    int            n_queries;
    int            n_checked;
    int            n_errors;

    function int unsigned eff_len();
      return (buf_len > DEPTH) ? DEPTH : buf_len;
    endfunction

    // Work out the match result at pos and the highest buffer index the search reads.
    function void predict_matches(input bit [15:0] pos, output match_result_t r,
                                  output int reach);
      int unsigned eff;
      int unsigned k;
      int unsigned run;
      bit [7:0]    d;
      r     = '0;
      r.qpos = pos;
      reach = -1;
      eff   = eff_len();
      if (pos < FIRST_POS || pos + MIN_RUN > eff) return;
      reach = pos;
      for (int j = 1; j <= NUM_DIST; j++) begin
        if (pos < j) continue;
        d = image[pos] - image[pos - j];
        if (d == 8'h00 || (d < DELTA_NEG_LIMIT && d > DELTA_POS_LIMIT)) continue;
        k = pos;
        while (k < eff && k - pos < MAX_RUN && image[k] == 8'(image[k - j] + d)) k++;
        // The walk reads the mismatching byte unless a limit stopped it.
        if (k < eff && k - pos < MAX_RUN) begin
          if (int'(k) > reach) reach = k;
        end else if (int'(k) - 1 > reach) begin
          reach = k - 1;
        end
        run = k - pos;
        if (run >= MIN_RUN) begin
          r.delta[j-1]   = d;
          r.run_len[j-1] = RUN_FIELD_W'((run > RUN_FIELD_MAX) ? RUN_FIELD_MAX : run);
        end
      end
    endfunction

    // Apply an accepted input transfer: store the byte or queue the expected result.
    function void note_transfer(input logic op, input bit [15:0] pos, input bit [7:0] val);
      match_result_t r;
      int            reach;
      if (op == OP_WRITE) begin
        image[pos]  = val;
        loaded[pos] = 1'b1;
        n_writes++;
      end else begin
        predict_matches(pos, r, reach);
        expected_matches = {expected_matches, r};
        n_queries++;
      end
    endfunction

    function void report_field(input string name, input string exp_s, input string got_s);
      n_errors++;
      $display("%0t: %s expected %s got %s", $time, name, exp_s, got_s);
    endfunction

    // Compare one output transfer with the oldest pending result.
    function void check_result(input logic [87:0] data);
      match_result_t got;
      match_result_t exp_r;
      got = data;
      n_checked++;
      if (expected_matches.size() == 0) begin
        report_field("query_position", "no result", $sformatf("%0d", got.qpos));
        return;
      end
      exp_r = expected_matches.pop_front();
      if (got.qpos !== exp_r.qpos)
        report_field("query_position", $sformatf("%0d", exp_r.qpos),
                     $sformatf("%0d", got.qpos));
      for (int j = 0; j < NUM_DIST; j++) begin
        if (got.delta[j] !== exp_r.delta[j])
          report_field($sformatf("delta_offset%0d @%0d", j + 1, exp_r.qpos),
                       $sformatf("%0d", $signed(exp_r.delta[j])),
                       $sformatf("%0d", $signed(got.delta[j])));
        if (got.run_len[j] !== exp_r.run_len[j])
          report_field($sformatf("run_length%0d @%0d", j + 1, exp_r.qpos),
                       $sformatf("%0d", exp_r.run_len[j]),
                       $sformatf("%0d", got.run_len[j]));
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] position, [23:16] byte_value
  logic [23:0] s_axis_tdata  = '0;
  // [0] operation
  logic        s_axis_tuser  = OP_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] query_position, [47:16] delta_offset1..4, [87:48] run_length1..4
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [16:0] cfg_wdata_i   = '0;

  match_scoreboard sb = new();
  int send_idle_pct = 9;
  int recv_idle_pct = 65;
  int hold_cycles   = 0;

  delta_sequence_match_finder_unit #(
    .BUFFER_DEPTH  (DEPTH),
    .MAX_RUN       (MAX_RUN),
    .MIN_RUN       (MIN_RUN),
    .FIRST_POSITION(FIRST_POS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_delta_sequence_match_finder_unit NOT OK");
    $finish;
  end

  // Result side: check each transfer, then pick tready (long hold-off first, else random).
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item, idling first at random, and return at the edge that takes it.
  task automatic send_item(input logic op, input logic [15:0] pos, input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_transfer(op, pos, val);
  endtask

  // Load every byte the search at pos may read, then send the query.
  task automatic query_at(input logic [15:0] pos);
    match_result_t r;
    int            reach;
    int            lo;
    int            hi;
    int            filled;
    do begin
      sb.predict_matches(pos, r, reach);
      filled = 0;
      if (reach >= 0) begin
        lo = int'(pos) - ((pos < NUM_DIST) ? int'(pos) : int'(NUM_DIST));
        hi = reach + 4;
        if (hi > int'(sb.eff_len()) - 1) hi = int'(sb.eff_len()) - 1;
        for (int i = lo; i <= hi; i++) begin
          if (!sb.loaded[i]) begin
            send_item(OP_WRITE, 16'(i), 8'($urandom));
            filled++;
          end
        end
      end
    end while (filled != 0);
    send_item(OP_QUERY, pos, 8'($urandom));
  endtask

  // Drop tvalid, wait out pending results, then let the last walk finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [16:0] len);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.buf_len = len;
  endtask

  // Write a constant-delta sequence at distance back_dist, sometimes with one broken byte.
  task automatic write_sequence(input int base, input int n, input int back_dist,
                                input bit [7:0] delta);
    bit [7:0] seq_bytes[$];
    bit [7:0] v;
    int       brk;
    brk = ($urandom_range(3) == 0) ? int'($urandom_range(n - 1)) : -1;
    for (int i = 0; i < n; i++) begin
      if (i < back_dist) v = 8'($urandom);
      else v = seq_bytes[i - back_dist] + delta;
      if (i == brk) v = v ^ 8'($urandom_range(1, 255));
      seq_bytes = {seq_bytes, v};
      send_item(OP_WRITE, 16'(base + i), v);
    end
  endtask

  // Mostly sequences followed by queries into them; the rest stray writes and queries.
  task automatic random_phase(input int n_items, input bit long_first);
    int         sent;
    int         eff;
    int         base;
    int         n;
    int         nq;
    int         qspan;
    int         choice;
    bit         go_long;
    bit [7:0]   delta;
    logic [15:0] pos;
    sent = 0;
    eff  = sb.eff_len();
    while (sent < n_items) begin
      choice  = $urandom_range(99);
      go_long = long_first && sent == 0;
      if (choice < 70 || go_long) begin
        if (go_long) begin
          n    = $urandom_range(530, 560);
          base = $urandom_range((eff > 600) ? eff - 600 : 0);
        end else begin
          n    = $urandom_range(2, 24);
          base = (eff > 0) ? int'($urandom_range(eff - 1)) : int'($urandom_range(16'hFFFF));
        end
        if (base + n > DEPTH) n = DEPTH - base;
        delta = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(128) - 64);
        write_sequence(base, n, $urandom_range(1, NUM_DIST), delta);
        // Start long-sequence queries early enough to hit the run cap.
        qspan = (n > MAX_RUN) ? n - MAX_RUN : n;
        nq    = $urandom_range(1, 4);
        repeat (nq) query_at(16'(base + $urandom_range(qspan)));
        sent += n + nq;
      end else if (choice < 85) begin
        send_item(OP_WRITE, 16'($urandom), 8'($urandom));
        sent++;
      end else begin
        case ($urandom_range(2))
          0:       pos = 16'($urandom);
          1:       pos = 16'(eff - 2 + $urandom_range(3));
          default: pos = 16'($urandom_range(NUM_DIST));
        endcase
        query_at(pos);
        sent++;
      end
    end
  endtask

  initial begin
    bit [7:0] head_bytes[8];
    head_bytes = '{8'd100, 8'd164, 8'd100, 8'd165, 8'd100, 8'd100, 8'd0, 8'd255};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length of one: nothing is in range.
    query_at(16'd0);
    query_at(16'd1);
    query_at(16'hFFFF);
    // Zero length answers zeros everywhere.
    write_length(17'd0);
    query_at(16'd0);
    query_at(16'd3);

    // Length above the buffer depth: window edges, rejected deltas, distances past position.
    write_length(17'h1FFFF);
    for (int i = 0; i < 8; i++) send_item(OP_WRITE, 16'(i), head_bytes[i]);
    for (int i = 1; i < 8; i++) query_at(16'(i));
    // Run that ends at the last buffer byte.
    for (int i = 65530; i < 65536; i++) send_item(OP_WRITE, 16'(i), 8'(i * 3));
    query_at(16'd65532);
    query_at(16'hFFFF);

    // Sender mostly busy, receiver mostly stalling.
    write_length(17'h10000);
    random_phase(110, 1'b1);
    write_length(17'($urandom_range(16, 400)));
    hold_cycles = 2000;
    random_phase(20, 1'b0);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 65;
    recv_idle_pct = 9;
    write_length(17'd1);
    random_phase(20, 1'b0);
    write_length(17'd65535);
    random_phase(20, 1'b0);

    // Full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_length(17'($urandom_range(2, 64)));
    random_phase(20, 1'b0);
    write_length(17'h1FFFF);
    random_phase(20, 1'b0);

    drain();
    $display("Run: %0d byte writes and %0d queries over lengths 0, 1, small, 65535, 65536",
             sb.n_writes, sb.n_queries);
    $display("and beyond the depth; %0d results compared, %0d field mismatches.",
             sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_matches.size() == 0) begin
      $display("tb_delta_sequence_match_finder_unit OK");
    end else begin
      $display("tb_delta_sequence_match_finder_unit NOT OK");
    end
    $finish;
  end

endmodule
